// ===== hdl/tcp_flow_event_counter_table_core_assert.svh =====
// Assertion macros used by the flow event counter table core.
`ifndef TCP_FLOW_EVENT_COUNTER_TABLE_CORE_ASSERT_SVH
`define TCP_FLOW_EVENT_COUNTER_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define TFEC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tfec assertion failed");

// Next-cycle implication, quiet during reset.
`define TFEC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tfec assertion failed");

`endif

// ===== hdl/tfec_pkg.sv =====
// Shared constants and types of the flow event counter table.
package tfec_pkg;

   localparam int FLOW_ENTRIES_DEF    = 8192;
   localparam int PROCESS_ENTRIES_DEF = 4096;
   localparam int TABLE_WAYS_DEF      = 4;
   localparam int COUNTER_BITS_DEF    = 32;

   localparam logic [15:0] FAMILY_INET           = 16'd2;
   localparam logic [3:0]  SOCK_STATE_OPEN       = 4'd1;
   localparam logic [3:0]  SOCK_STATE_DIALING    = 4'd2;
   localparam logic [3:0]  SOCK_STATE_SHUT_LOCAL = 4'd4;
   localparam logic [3:0]  SOCK_STATE_SHUT_PEER  = 4'd8;

   localparam logic [1:0] KIND_IGNORED = 2'd0;
   localparam logic [1:0] KIND_CONNECT = 2'd1;
   localparam logic [1:0] KIND_CLOSE   = 2'd2;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CALC
   } state_type;

endpackage

// ===== hdl/tfec_set_table.sv =====
// One set-associative table: key, data and replacement memories, one row per set.
module tfec_set_table import tfec_pkg::*; #(
   parameter int SETS      = 1024,
   parameter int WAYS      = 4,
   parameter int KEY_BITS  = 32,
   parameter int DATA_BITS = 32,
   parameter int AGE_BITS  = 2,
   parameter int SET_BITS  = 10
) (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [SET_BITS-1:0]                 rd_set,
   output logic [WAYS-1:0][KEY_BITS-1:0]       rd_key,
   output logic [WAYS-1:0][DATA_BITS-1:0]      rd_data,
   output logic [WAYS-1:0]                     rd_valid,
   output logic [WAYS-1:0][AGE_BITS-1:0]       rd_age,
   input  logic                                wr_row_en,
   input  logic                                wr_meta_en,
   input  logic [SET_BITS-1:0]                 wr_set,
   input  logic [WAYS-1:0][KEY_BITS-1:0]       wr_key,
   input  logic [WAYS-1:0][DATA_BITS-1:0]      wr_data,
   input  logic [WAYS-1:0]                     wr_valid,
   input  logic [WAYS-1:0][AGE_BITS-1:0]       wr_age
);

   logic [WAYS-1:0][KEY_BITS-1:0]  key_mem   [SETS];
   logic [WAYS-1:0][DATA_BITS-1:0] data_mem  [SETS];
   logic [WAYS-1:0]                valid_mem [SETS];
   logic [WAYS-1:0][AGE_BITS-1:0]  age_mem   [SETS];

   logic [WAYS-1:0][KEY_BITS-1:0]  rd_key_ff;
   logic [WAYS-1:0][DATA_BITS-1:0] rd_data_ff;
   logic [WAYS-1:0]                rd_valid_ff;
   logic [WAYS-1:0][AGE_BITS-1:0]  rd_age_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff   <= key_mem[rd_set];
         rd_data_ff  <= data_mem[rd_set];
         rd_valid_ff <= valid_mem[rd_set];
         rd_age_ff   <= age_mem[rd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_row_en) begin
         key_mem[wr_set]  <= wr_key;
         data_mem[wr_set] <= wr_data;
      end
      if (wr_meta_en) begin
         valid_mem[wr_set] <= wr_valid;
         age_mem[wr_set]   <= wr_age;
      end
   end

   assign rd_key   = rd_key_ff;
   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;
   assign rd_age   = rd_age_ff;

endmodule

// ===== hdl/tcp_flow_event_counter_table_core.sv =====
// Top level of the TCP flow event counter table.
// Request words and table rows are registered on acceptance, results at write-back.
// A new word is taken only once the last is written back (read, then update and
// write-back); a held result stalls the update and keeps req_ready low.
// Reset: a sweep of max(FLOW_ENTRIES, PROCESS_ENTRIES) / TABLE_WAYS set rows (2048
// by default) clears valid bits, sets ages to way index; req_ready low until done.
module tcp_flow_event_counter_table_core import tfec_pkg::*; #(
   parameter int FLOW_ENTRIES    = FLOW_ENTRIES_DEF,
   parameter int PROCESS_ENTRIES = PROCESS_ENTRIES_DEF,
   parameter int TABLE_WAYS      = TABLE_WAYS_DEF,
   parameter int COUNTER_BITS    = COUNTER_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_address_family,
   input  logic [31:0] req_process_id,
   input  logic [3:0]  req_old_tcp_state,
   input  logic [3:0]  req_new_tcp_state,
   input  logic [31:0] req_dest_address,
   input  logic [63:0] req_event_time,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic        rsp_flow_created,
   output logic        rsp_flow_evicted,
   output logic [31:0] rsp_flow_connects,
   output logic [31:0] rsp_flow_closes,
   output logic [63:0] rsp_flow_first_time,
   output logic [31:0] rsp_process_connects
);

   `include "tcp_flow_event_counter_table_core_assert.svh"

   localparam int FLOW_SETS = FLOW_ENTRIES / TABLE_WAYS;
   localparam int PROC_SETS = PROCESS_ENTRIES / TABLE_WAYS;
   localparam int MAX_SETS  = (FLOW_SETS > PROC_SETS) ? FLOW_SETS : PROC_SETS;
   localparam int FSET_BITS = (FLOW_SETS > 1) ? $clog2(FLOW_SETS) : 1;
   localparam int PSET_BITS = (PROC_SETS > 1) ? $clog2(PROC_SETS) : 1;
   localparam int CLR_BITS  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_BITS  = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
   localparam int CB        = COUNTER_BITS;
   localparam int FKEY_BITS = 64;
   localparam int FDATA_BITS = 64 + 2 * CB;
   localparam int PKEY_BITS = 32;

   // ------------------------------------------------------------------
   // Control and request registers
   // ------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [CLR_BITS-1:0] clr_cnt_ff, clr_cnt_in;

   logic [15:0] family_ff;
   logic [31:0] pid_ff;
   logic [3:0]  old_state_ff;
   logic [3:0]  new_state_ff;
   logic [31:0] dest_ff;
   logic [63:0] time_ff;

   logic req_take;
   logic rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // Hold the request word for the update cycle.
   always_ff @(posedge clock) begin
      if (req_take) begin
         family_ff    <= req_address_family;
         pid_ff       <= req_process_id;
         old_state_ff <= req_old_tcp_state;
         new_state_ff <= req_new_tcp_state;
         dest_ff      <= req_dest_address;
         time_ff      <= req_event_time;
      end
   end

   // ------------------------------------------------------------------
   // Tables
   // ------------------------------------------------------------------
   logic [FSET_BITS-1:0] f_rd_set, f_wr_set;
   logic [PSET_BITS-1:0] p_rd_set, p_wr_set;
   logic [31:0]          f_mix_req, f_mix_ff;

   assign f_mix_req = req_process_id ^ req_dest_address;
   assign f_mix_ff  = pid_ff ^ dest_ff;
   assign f_rd_set  = f_mix_req[FSET_BITS-1:0];
   assign p_rd_set  = req_process_id[PSET_BITS-1:0];

   logic [TABLE_WAYS-1:0][FKEY_BITS-1:0]  f_rd_key, f_wr_key;
   logic [TABLE_WAYS-1:0][FDATA_BITS-1:0] f_rd_data, f_wr_data;
   logic [TABLE_WAYS-1:0]                 f_rd_valid, f_wr_valid;
   logic [TABLE_WAYS-1:0][WAY_BITS-1:0]   f_rd_age, f_wr_age;
   logic                                  f_wr_row, f_wr_meta;

   logic [TABLE_WAYS-1:0][PKEY_BITS-1:0]  p_rd_key, p_wr_key;
   logic [TABLE_WAYS-1:0][CB-1:0]         p_rd_data, p_wr_data;
   logic [TABLE_WAYS-1:0]                 p_rd_valid, p_wr_valid;
   logic [TABLE_WAYS-1:0][WAY_BITS-1:0]   p_rd_age, p_wr_age;
   logic                                  p_wr_row, p_wr_meta;

   // Metadata written to the tables: cleared rows during the sweep, updates otherwise.
   logic [TABLE_WAYS-1:0][WAY_BITS-1:0] f_meta_age, p_meta_age;
   logic [TABLE_WAYS-1:0]               f_meta_valid, p_meta_valid;

   tfec_set_table #(
      .SETS      (FLOW_SETS),
      .WAYS      (TABLE_WAYS),
      .KEY_BITS  (FKEY_BITS),
      .DATA_BITS (FDATA_BITS),
      .AGE_BITS  (WAY_BITS),
      .SET_BITS  (FSET_BITS)
   ) u_flow_table (
      .clock      (clock),
      .rd_en      (req_take),
      .rd_set     (f_rd_set),
      .rd_key     (f_rd_key),
      .rd_data    (f_rd_data),
      .rd_valid   (f_rd_valid),
      .rd_age     (f_rd_age),
      .wr_row_en  (f_wr_row),
      .wr_meta_en (f_wr_meta),
      .wr_set     (f_wr_set),
      .wr_key     (f_wr_key),
      .wr_data    (f_wr_data),
      .wr_valid   (f_meta_valid),
      .wr_age     (f_meta_age)
   );

   tfec_set_table #(
      .SETS      (PROC_SETS),
      .WAYS      (TABLE_WAYS),
      .KEY_BITS  (PKEY_BITS),
      .DATA_BITS (CB),
      .AGE_BITS  (WAY_BITS),
      .SET_BITS  (PSET_BITS)
   ) u_proc_table (
      .clock      (clock),
      .rd_en      (req_take),
      .rd_set     (p_rd_set),
      .rd_key     (p_rd_key),
      .rd_data    (p_rd_data),
      .rd_valid   (p_rd_valid),
      .rd_age     (p_rd_age),
      .wr_row_en  (p_wr_row),
      .wr_meta_en (p_wr_meta),
      .wr_set     (p_wr_set),
      .wr_key     (p_wr_key),
      .wr_data    (p_wr_data),
      .wr_valid   (p_meta_valid),
      .wr_age     (p_meta_age)
   );

   // ------------------------------------------------------------------
   // Event classification
   // ------------------------------------------------------------------
   logic is_conn, is_clos, counted;
   logic [63:0] f_key;

   assign is_conn = (old_state_ff == SOCK_STATE_DIALING) && (new_state_ff == SOCK_STATE_OPEN);
   assign is_clos = (old_state_ff == SOCK_STATE_OPEN) &&
                    ((new_state_ff == SOCK_STATE_SHUT_PEER) ||
                     (new_state_ff == SOCK_STATE_SHUT_LOCAL));
   assign counted = (family_ff == FAMILY_INET) && (pid_ff != 32'd0) && (is_conn || is_clos);
   assign f_key   = {pid_ff, dest_ff};

   // ------------------------------------------------------------------
   // Flow table update: hit search, victim choice, ageing, counters
   // ------------------------------------------------------------------
   logic                  f_hit, f_inv;
   logic [WAY_BITS-1:0]   f_hway, f_vway, f_way;
   logic [WAY_BITS-1:0]   f_sel_age;
   logic [FDATA_BITS-1:0] f_cur, f_new;
   logic [CB-1:0]         f_cur_conn, f_cur_clos, f_new_conn, f_new_clos;
   logic [63:0]           f_new_time;

   always_comb begin
      f_hit  = 1'b0;
      f_hway = '0;
      f_inv  = 1'b0;
      f_vway = '0;
      for (int i = 0; i < TABLE_WAYS; i++) begin
         if (!f_hit && f_rd_valid[i] && (f_rd_key[i] == f_key)) begin
            f_hit  = 1'b1;
            f_hway = WAY_BITS'(i);
         end
         if (!f_inv && !f_rd_valid[i]) begin
            f_inv  = 1'b1;
            f_vway = WAY_BITS'(i);
         end
      end
      // Full set: replace the oldest way.
      if (!f_inv) begin
         for (int i = 0; i < TABLE_WAYS; i++) begin
            if (f_rd_age[i] == WAY_BITS'(TABLE_WAYS - 1)) begin
               f_vway = WAY_BITS'(i);
            end
         end
      end
      f_way      = f_hit ? f_hway : f_vway;
      f_sel_age  = f_rd_age[f_way];
      f_cur      = f_rd_data[f_way];
      f_cur_conn = f_cur[CB-1:0];
      f_cur_clos = f_cur[2*CB-1:CB];
      if (f_hit) begin
         f_new_conn = (is_conn && (f_cur_conn != '1)) ? f_cur_conn + 1'b1 : f_cur_conn;
         f_new_clos = (is_clos && (f_cur_clos != '1)) ? f_cur_clos + 1'b1 : f_cur_clos;
         f_new_time = f_cur[FDATA_BITS-1:2*CB];
      end else begin
         f_new_conn = CB'(is_conn);
         f_new_clos = CB'(is_clos);
         f_new_time = time_ff;
      end
      f_new = {f_new_time, f_new_clos, f_new_conn};

      f_wr_key   = f_rd_key;
      f_wr_data  = f_rd_data;
      f_wr_valid = f_rd_valid;
      for (int i = 0; i < TABLE_WAYS; i++) begin
         if (f_rd_age[i] < f_sel_age) begin
            f_wr_age[i] = f_rd_age[i] + 1'b1;
         end else begin
            f_wr_age[i] = f_rd_age[i];
         end
      end
      f_wr_age[f_way]   = '0;
      f_wr_key[f_way]   = f_key;
      f_wr_data[f_way]  = f_new;
      f_wr_valid[f_way] = 1'b1;
   end

   // ------------------------------------------------------------------
   // Process table update: connects touch it, closes only look
   // ------------------------------------------------------------------
   logic                p_hit, p_inv;
   logic [WAY_BITS-1:0] p_hway, p_vway, p_way;
   logic [WAY_BITS-1:0] p_sel_age;
   logic [CB-1:0]       p_cur, p_new, p_count;

   always_comb begin
      p_hit  = 1'b0;
      p_hway = '0;
      p_inv  = 1'b0;
      p_vway = '0;
      for (int i = 0; i < TABLE_WAYS; i++) begin
         if (!p_hit && p_rd_valid[i] && (p_rd_key[i] == pid_ff)) begin
            p_hit  = 1'b1;
            p_hway = WAY_BITS'(i);
         end
         if (!p_inv && !p_rd_valid[i]) begin
            p_inv  = 1'b1;
            p_vway = WAY_BITS'(i);
         end
      end
      if (!p_inv) begin
         for (int i = 0; i < TABLE_WAYS; i++) begin
            if (p_rd_age[i] == WAY_BITS'(TABLE_WAYS - 1)) begin
               p_vway = WAY_BITS'(i);
            end
         end
      end
      p_way     = p_hit ? p_hway : p_vway;
      p_sel_age = p_rd_age[p_way];
      p_cur     = p_rd_data[p_way];
      if (p_hit) begin
         p_new = (p_cur != '1) ? p_cur + 1'b1 : p_cur;
      end else begin
         p_new = CB'(1);
      end
      if (is_conn) begin
         p_count = p_new;
      end else if (p_hit) begin
         p_count = p_cur;
      end else begin
         p_count = '0;
      end

      p_wr_key   = p_rd_key;
      p_wr_data  = p_rd_data;
      p_wr_valid = p_rd_valid;
      for (int i = 0; i < TABLE_WAYS; i++) begin
         if (p_rd_age[i] < p_sel_age) begin
            p_wr_age[i] = p_rd_age[i] + 1'b1;
         end else begin
            p_wr_age[i] = p_rd_age[i];
         end
      end
      p_wr_age[p_way]   = '0;
      p_wr_key[p_way]   = pid_ff;
      p_wr_data[p_way]  = p_new;
      p_wr_valid[p_way] = 1'b1;
   end

   // ------------------------------------------------------------------
   // Sequencer: clear, idle, update
   // ------------------------------------------------------------------
   logic [TABLE_WAYS-1:0][WAY_BITS-1:0] clr_age;

   always_comb begin
      for (int i = 0; i < TABLE_WAYS; i++) begin
         clr_age[i] = WAY_BITS'(i);
      end
   end

   assign rsp_load = (state_ff == ST_CALC) && (!rsp_valid || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      f_wr_row     = 1'b0;
      f_wr_meta    = 1'b0;
      p_wr_row     = 1'b0;
      p_wr_meta    = 1'b0;
      f_wr_set     = f_mix_ff[FSET_BITS-1:0];
      p_wr_set     = pid_ff[PSET_BITS-1:0];
      f_meta_valid = f_wr_valid;
      f_meta_age   = f_wr_age;
      p_meta_valid = p_wr_valid;
      p_meta_age   = p_wr_age;
      case (state_ff)
         ST_CLEAR: begin
            // Sweep one set row per cycle through both tables.
            f_wr_set     = FSET_BITS'(clr_cnt_ff);
            p_wr_set     = PSET_BITS'(clr_cnt_ff);
            f_meta_valid = '0;
            f_meta_age   = clr_age;
            p_meta_valid = '0;
            p_meta_age   = clr_age;
            f_wr_meta    = (32'(clr_cnt_ff) < FLOW_SETS);
            p_wr_meta    = (32'(clr_cnt_ff) < PROC_SETS);
            if (clr_cnt_ff == CLR_BITS'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            // Write back once the result register can take the word.
            if (rsp_load) begin
               f_wr_row  = counted;
               f_wr_meta = counted;
               p_wr_row  = counted && is_conn;
               p_wr_meta = counted && is_conn;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic        rsp_valid_ff;
   logic [1:0]  kind_ff;
   logic        created_ff, evicted_ff;
   logic [31:0] f_conn_ff, f_clos_ff, p_conn_ff;
   logic [63:0] f_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         if (counted) begin
            kind_ff    <= is_conn ? KIND_CONNECT : KIND_CLOSE;
            created_ff <= !f_hit;
            evicted_ff <= !f_hit && f_rd_valid[f_way];
            f_conn_ff  <= 32'(f_new_conn);
            f_clos_ff  <= 32'(f_new_clos);
            f_time_ff  <= f_new_time;
            p_conn_ff  <= 32'(p_count);
         end else begin
            kind_ff    <= KIND_IGNORED;
            created_ff <= 1'b0;
            evicted_ff <= 1'b0;
            f_conn_ff  <= '0;
            f_clos_ff  <= '0;
            f_time_ff  <= '0;
            p_conn_ff  <= '0;
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_event_kind       = kind_ff;
   assign rsp_flow_created     = created_ff;
   assign rsp_flow_evicted     = evicted_ff;
   assign rsp_flow_connects    = f_conn_ff;
   assign rsp_flow_closes      = f_clos_ff;
   assign rsp_flow_first_time  = f_time_ff;
   assign rsp_process_connects = p_conn_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `TFEC_ASSERT_NEXT(a_take_to_calc, clock, reset, req_take, state_ff == ST_CALC)
   `TFEC_ASSERT_NOW(a_row_write_in_calc, clock, reset, f_wr_row || p_wr_row, rsp_load)
   `TFEC_ASSERT_NOW(a_evict_means_create, clock, reset, rsp_valid && rsp_flow_evicted,
                    rsp_flow_created)
   `TFEC_ASSERT_NOW(a_ignored_quiet, clock, reset,
                    rsp_valid && (rsp_event_kind == KIND_IGNORED),
                    !rsp_flow_created && (rsp_flow_connects == 32'd0))

endmodule
